[hw/rtl/dmva_pkg.sv]
// ----------------------------------------------------------------------------
// dmva_pkg
// Shared types and constants for the dual matrix-vector accumulator:
// request and result payloads, op codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dmva_pkg;

    // default vector length and memory depth
    localparam int unsigned MAX_DIM_DEFAULT = 64;

    // field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned DIM_W   = 7;
    localparam int unsigned PROD_W  = 64;

    // dimension register value after reset
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // op codes, code three is unused
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_MATRIX = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // request payload
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] matrix_value;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
        logic signed [DATA_W-1:0] z_value;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic signed [DATA_W-1:0] y_result;
        logic signed [DATA_W-1:0] z_result;
        logic                     saturated_flag;
        logic                     bad_index_flag;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_FETCH,
        S_MULT,
        S_ACCUM,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic write_load;
        logic mult;
        logic accum;
        logic result;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_load;
        logic in_matrix;
        logic in_read;
        logic in_ok;
        logic held_matrix;
    } t_status;

endpackage

[hw/rtl/dmva_datapath.sv]
// ----------------------------------------------------------------------------
// dmva_datapath
// Request registers, the x/y/z vector memories, the two Q16.16 multipliers,
// saturating accumulation, sticky flags and the registered result.
// ----------------------------------------------------------------------------
module dmva_datapath
    import dmva_pkg::*;
#(
    parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_cfg_data,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_result_valid,
    output t_out_item        o_result
);

    localparam int unsigned AW = $clog2(MAX_DIM);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_mac;

    // acc + floor(prod / 2^16), saturated to 32 bits
    function automatic t_mac sat_add(input logic [DATA_W-1:0] acc,
                                     input logic [PROD_W-1:0] prod);
        logic [48:0] sum;
        t_mac        res;
        sum = {{17{acc[DATA_W-1]}}, acc} + {prod[PROD_W-1], prod[PROD_W-1:16]};
        if (sum[48:31] != {18{sum[48]}}) begin
            res.sat   = 1'b1;
            res.value = sum[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res.sat   = 1'b0;
            res.value = sum[DATA_W-1:0];
        end
        return res;
    endfunction

    logic [DIM_W-1:0]         r_dim;
    logic                     r_sat_seen;
    logic                     r_bad_seen;
    logic [OP_W-1:0]          r_op;
    logic [IDX_W-1:0]         r_row;
    logic [IDX_W-1:0]         r_col;
    logic                     r_ok;
    logic signed [DATA_W-1:0] r_a;
    logic [DATA_W-1:0]        r_xv;
    logic [DATA_W-1:0]        r_yv;
    logic [DATA_W-1:0]        r_zv;

    logic [DATA_W-1:0]        x_mem [MAX_DIM];
    logic [DATA_W-1:0]        y_mem [MAX_DIM];
    logic [DATA_W-1:0]        z_mem [MAX_DIM];
    logic [DATA_W-1:0]        r_x_row;
    logic [DATA_W-1:0]        r_x_col;
    logic [DATA_W-1:0]        r_y_rd;
    logic [DATA_W-1:0]        r_z_rd;
    logic [PROD_W-1:0]        r_prod_y;
    logic [PROD_W-1:0]        r_prod_z;

    logic                     r_valid;
    t_out_item                r_out;

    logic                     row_ok;
    logic                     col_ok;
    logic [AW-1:0]            row_addr;
    logic [AW-1:0]            col_addr;
    logic [AW-1:0]            y_rd_addr;
    t_mac                     mac_y;
    t_mac                     mac_z;

    // index checks on the incoming request
    assign row_ok = ({1'b0, i_item.row_index} < r_dim) && (32'(i_item.row_index) < MAX_DIM);
    assign col_ok = ({1'b0, i_item.col_index} < r_dim) && (32'(i_item.col_index) < MAX_DIM);

    always_comb begin
        o_status             = '0;
        o_status.held_matrix = (r_op == OP_MATRIX);
        unique case (i_item.op)
            OP_LOAD: begin
                o_status.in_load = 1'b1;
                o_status.in_ok   = row_ok;
            end
            OP_MATRIX: begin
                o_status.in_matrix = 1'b1;
                o_status.in_ok     = row_ok && col_ok;
            end
            OP_READ: begin
                o_status.in_read = 1'b1;
                o_status.in_ok   = row_ok;
            end
            default: begin
                o_status.in_ok = 1'b0;
            end
        endcase
    end

    // configuration and sticky flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim      <= DIM_RESET;
            r_sat_seen <= 1'b0;
            r_bad_seen <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dim <= i_cfg_data;
            end
            if (i_cmd.capture && !o_status.in_ok &&
                (o_status.in_load || o_status.in_matrix || o_status.in_read)) begin
                r_bad_seen <= 1'b1;
            end
            if (i_cmd.accum && (mac_y.sat || mac_z.sat)) begin
                r_sat_seen <= 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_item.op;
            r_row <= i_item.row_index;
            r_col <= i_item.col_index;
            r_ok  <= o_status.in_ok;
            r_a   <= i_item.matrix_value;
            r_xv  <= i_item.x_value;
            r_yv  <= i_item.y_value;
            r_zv  <= i_item.z_value;
        end
    end

    assign row_addr  = AW'(r_row);
    assign col_addr  = AW'(r_col);
    assign y_rd_addr = o_status.held_matrix ? col_addr : row_addr;

    // x memory, two read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_load) begin
            x_mem[row_addr] <= r_xv;
        end
        r_x_row <= x_mem[row_addr];
        r_x_col <= x_mem[col_addr];
    end

    // y memory, indexed by column for matrix updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_load) begin
            y_mem[row_addr] <= r_yv;
        end else if (i_cmd.accum) begin
            y_mem[col_addr] <= mac_y.value;
        end
        r_y_rd <= y_mem[y_rd_addr];
    end

    // z memory, indexed by row
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_load) begin
            z_mem[row_addr] <= r_zv;
        end else if (i_cmd.accum) begin
            z_mem[row_addr] <= mac_z.value;
        end
        r_z_rd <= z_mem[row_addr];
    end

    // products, registered ahead of the accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod_y <= PROD_W'(64'(r_a) * 64'(signed'(r_x_row)));
            r_prod_z <= PROD_W'(64'(r_a) * 64'(signed'(r_x_col)));
        end
    end

    assign mac_y = sat_add(r_y_rd, r_prod_y);
    assign mac_z = sat_add(r_z_rd, r_prod_z);

    // result register, one cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_out.y_result       <= r_ok ? r_y_rd : '0;
            r_out.z_result       <= r_ok ? r_z_rd : '0;
            r_out.saturated_flag <= r_sat_seen;
            r_out.bad_index_flag <= r_bad_seen;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_out;

    // sticky flags never clear outside reset
    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat_seen |=> r_sat_seen)
        else $error("saturation flag cleared");

    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad_seen |=> r_bad_seen)
        else $error("bad index flag cleared");

    // a bad index read returns zero data
    a_bad_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.result && !r_ok) |=> (r_out.y_result == '0 && r_out.z_result == '0))
        else $error("bad index read returned data");

endmodule

[hw/rtl/dmva_ctrl.sv]
// ----------------------------------------------------------------------------
// dmva_ctrl
// Sequencer for one request at a time: load write, matrix fetch/multiply/
// accumulate, or read fetch and result strobe.
// ----------------------------------------------------------------------------
module dmva_ctrl
    import dmva_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output logic    busy,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_status.in_load && i_status.in_ok) begin
                        n_state = S_WRITE;
                    end else if (i_status.in_matrix && i_status.in_ok) begin
                        n_state = S_FETCH;
                    end else if (i_status.in_read) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_WRITE:  n_state = S_IDLE;
            S_FETCH:  n_state = i_status.held_matrix ? S_MULT : S_RESULT;
            S_MULT:   n_state = S_ACCUM;
            S_ACCUM:  n_state = S_IDLE;
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            S_WRITE:  o_cmd.write_load = 1'b1;
            S_FETCH:  o_cmd = '0;
            S_MULT:   o_cmd.mult = 1'b1;
            S_ACCUM:  o_cmd.accum = 1'b1;
            S_RESULT: o_cmd.result = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    // multiply always follows the fetch
    a_mult_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULT) |-> ($past(r_state) == S_FETCH))
        else $error("multiply without fetch");

    // accepted read request goes to fetch
    a_read_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_status.in_read) |=> (r_state == S_FETCH))
        else $error("read request not fetched");

    // accumulate ends the matrix sequence
    a_accum_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCUM) |=> (r_state == S_IDLE))
        else $error("accumulate did not finish");

endmodule

[hw/rtl/dual_matrix_vector_accumulate.sv]
// ----------------------------------------------------------------------------
// dual_matrix_vector_accumulate
// Computes y += transpose(A)*x and z += A*x in signed Q16.16, one matrix
// element per request, with saturating sums and sticky status flags.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request keeps
// busy high through the write state, a matrix element through fetch, multiply
// and accumulate (memory fetch, multiply, saturating accumulate, write-back),
// a read through fetch and result, after which its result appears on o_result
// with o_result_valid high for exactly one cycle. A load or matrix request with
// a bad index, or the unused op code, is absorbed in its accept cycle; a read
// with a bad index still takes the full read sequence and returns zero data
// with the current flags. Request spacing is set by the request register, the
// registered memory reads and the register after the multipliers, with one
// request in flight at a time. The result cannot be held off: sample it on
// the strobe. Vector entries are undefined until loaded.
// ----------------------------------------------------------------------------
module dual_matrix_vector_accumulate
    import dmva_pkg::*;
#(
    parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    output logic             o_result_valid,
    output t_out_item        o_result,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    dmva_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // memories and arithmetic
    dmva_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dual_matrix_vector_accumulate. A queue of load,
// matrix-element and read requests feeds a clocked driver. An internal Q16.16
// predictor tracks x, y, z and the sticky flags, and a monitor checks every
// read result against it while the dimension register steps through
// several settings.
// ----------------------------------------------------------------------------
module tb;
    import dmva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_DIM       = MAX_DIM_DEFAULT;
    localparam int unsigned CLK_HALF      = 4;
    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [PROD_W-1:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SUM_MIN = -64'sd2147483648;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    t_in_item         i_item         = '0;
    logic             o_result_valid;
    t_out_item        o_result;
    logic             i_cfg_we       = 1'b0;
    logic [DIM_W-1:0] i_cfg_data     = '0;

    // requests waiting for the driver, reads waiting for their result
    t_in_item  pending_requests [$];
    t_out_item expected_reads [$];

    // predicted block state
    logic signed [DATA_W-1:0] x_entries [MAX_DIM];
    logic signed [DATA_W-1:0] y_sums [MAX_DIM];
    logic signed [DATA_W-1:0] z_sums [MAX_DIM];
    logic                     saturation_seen = 1'b0;
    logic                     index_error_seen = 1'b0;
    int unsigned              dim_setting = DIM_RESET;

    // entries loaded so far, as seen by the request generator
    bit gen_loaded [MAX_DIM];

    int unsigned send_idle_pct = 0;
    int unsigned stall_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned n_settings = 1;
    int unsigned n_load = 0;
    int unsigned n_matrix = 0;
    int unsigned n_read = 0;
    int unsigned n_bad = 0;
    int unsigned n_unused = 0;

    dual_matrix_vector_accumulate #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // index check against the current dimension and the memory depth
    function automatic bit index_valid(input int unsigned idx);
        return idx < dim_setting && idx < MAX_DIM;
    endfunction

    // acc + floor(a*b / 2^16), clamped to 32 bits
    function automatic logic signed [DATA_W-1:0] mac_q16(
        input logic signed [DATA_W-1:0] acc,
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sum;
        prod = {{DATA_W{a[DATA_W-1]}}, a} * {{DATA_W{b[DATA_W-1]}}, b};
        sum  = acc + (prod >>> 16);
        if (sum > SUM_MAX) begin
            saturation_seen = 1'b1;
            return SUM_MAX[DATA_W-1:0];
        end
        if (sum < SUM_MIN) begin
            saturation_seen = 1'b1;
            return SUM_MIN[DATA_W-1:0];
        end
        return sum[DATA_W-1:0];
    endfunction

    // apply one accepted request to the predicted accumulators
    task automatic advance_accumulators(input t_in_item req);
        bit        row_ok;
        bit        col_ok;
        t_out_item res;
        row_ok = index_valid(int'(req.row_index));
        col_ok = index_valid(int'(req.col_index));
        case (req.op)
            OP_LOAD: begin
                n_load++;
                if (!row_ok) begin
                    index_error_seen = 1'b1;
                    n_bad++;
                end else begin
                    x_entries[req.row_index] = req.x_value;
                    y_sums[req.row_index]    = req.y_value;
                    z_sums[req.row_index]    = req.z_value;
                end
            end
            OP_MATRIX: begin
                n_matrix++;
                if (!row_ok || !col_ok) begin
                    index_error_seen = 1'b1;
                    n_bad++;
                end else begin
                    y_sums[req.col_index] = mac_q16(y_sums[req.col_index],
                        req.matrix_value, x_entries[req.row_index]);
                    z_sums[req.row_index] = mac_q16(z_sums[req.row_index],
                        req.matrix_value, x_entries[req.col_index]);
                end
            end
            OP_READ: begin
                n_read++;
                if (row_ok) begin
                    res.y_result = y_sums[req.row_index];
                    res.z_result = z_sums[req.row_index];
                end else begin
                    index_error_seen = 1'b1;
                    n_bad++;
                    res.y_result = '0;
                    res.z_result = '0;
                end
                res.saturated_flag = saturation_seen;
                res.bad_index_flag = index_error_seen;
                expected_reads.push_back(res);
            end
            default: begin
                n_unused++;
            end
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                advance_accumulators(i_item);
            end
            if (!start || !busy) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    start  <= 1'b1;
                    i_item <= pending_requests.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (expected_reads.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual %h", $time, o_result);
            end else begin
                want = expected_reads.pop_front();
                results_checked++;
                if (o_result.y_result !== want.y_result) begin
                    mismatches++;
                    $display("%0t: y_result expected %h actual %h",
                        $time, want.y_result, o_result.y_result);
                end
                if (o_result.z_result !== want.z_result) begin
                    mismatches++;
                    $display("%0t: z_result expected %h actual %h",
                        $time, want.z_result, o_result.z_result);
                end
                if (o_result.saturated_flag !== want.saturated_flag) begin
                    mismatches++;
                    $display("%0t: saturated_flag expected %b actual %b",
                        $time, want.saturated_flag, o_result.saturated_flag);
                end
                if (o_result.bad_index_flag !== want.bad_index_flag) begin
                    mismatches++;
                    $display("%0t: bad_index_flag expected %b actual %b",
                        $time, want.bad_index_flag, o_result.bad_index_flag);
                end
            end
        end
    end

    // cycles without any accepted request or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // mostly Q16.16 values near one, some wide, some at the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        end
        if (roll < 70) begin
            return $urandom_range(32'h0100_0000) - 32'h0080_0000;
        end
        if (roll < 85) begin
            return $urandom;
        end
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0001_0000;
        endcase
    endfunction

    task automatic push_request(
        input logic [OP_W-1:0]   op,
        input int unsigned       row,
        input int unsigned       col,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] xv,
        input logic [DATA_W-1:0] yv,
        input logic [DATA_W-1:0] zv
    );
        t_in_item req;
        req.op           = op;
        req.row_index    = IDX_W'(row);
        req.col_index    = IDX_W'(col);
        req.matrix_value = a;
        req.x_value      = xv;
        req.y_value      = yv;
        req.z_value      = zv;
        if (op == OP_LOAD && index_valid(row)) begin
            gen_loaded[row] = 1'b1;
        end
        pending_requests.push_back(req);
    endtask

    // random request that never touches an entry that was never loaded
    task automatic push_random_request();
        int unsigned     lim;
        int unsigned     roll;
        int unsigned     row;
        int unsigned     col;
        int unsigned     ready [$];
        logic [OP_W-1:0] op;
        lim = (dim_setting < MAX_DIM) ? dim_setting : MAX_DIM;
        for (int i = 0; i < lim; i++) begin
            if (gen_loaded[i]) begin
                ready.push_back(i);
            end
        end
        roll = $urandom_range(99);
        if (lim == 0 || roll < 10) begin
            // noise: any op, any index, any payload
            op  = OP_W'($urandom_range(3));
            row = $urandom_range(MAX_DIM - 1);
            col = $urandom_range(MAX_DIM - 1);
            if ((op == OP_MATRIX && index_valid(row) && index_valid(col)
                    && !(gen_loaded[row] && gen_loaded[col]))
                || (op == OP_READ && index_valid(row) && !gen_loaded[row])) begin
                op = OP_UNUSED;
            end
            push_request(op, row, col, $urandom, $urandom, $urandom, $urandom);
        end else if (ready.size() == 0 || roll < 30) begin
            row = $urandom_range(lim - 1);
            push_request(OP_LOAD, row, $urandom_range(MAX_DIM - 1), $urandom,
                pick_value(), pick_value(), pick_value());
        end else if (roll < 78) begin
            row = ready[$urandom_range(ready.size() - 1)];
            col = ready[$urandom_range(ready.size() - 1)];
            push_request(OP_MATRIX, row, col, pick_value(), $urandom, $urandom, $urandom);
        end else begin
            row = ready[$urandom_range(ready.size() - 1)];
            push_request(OP_READ, row, $urandom_range(MAX_DIM - 1), $urandom,
                $urandom, $urandom, $urandom);
        end
    endtask

    task automatic push_random_requests(input int unsigned count);
        repeat (count) push_random_request();
    endtask

    // wait until every request is taken and every read has returned
    task automatic drain_requests();
        while (pending_requests.size() != 0 || start || expected_reads.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic change_dimension(input int unsigned dim, input int unsigned idle_pct);
        drain_requests();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= DIM_W'(dim);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dim_setting = dim;
        n_settings++;
        send_idle_pct = idle_pct;
        @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 30;
        @(negedge i_clk);

        // reset dimension: loads at both ends, truncation and saturation corners
        push_request(OP_LOAD, 0, 0, 0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        push_request(OP_LOAD, 63, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        push_request(OP_LOAD, 1, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        push_request(OP_LOAD, 2, 0, 0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        push_request(OP_LOAD, 3, 0, 0, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        push_request(OP_READ, 0, 0, 0, 0, 0, 0);
        push_request(OP_MATRIX, 0, 0, 32'h0002_0000, 0, 0, 0);
        push_request(OP_READ, 0, 0, 0, 0, 0, 0);
        // back-to-back updates of one entry
        push_request(OP_MATRIX, 0, 0, 32'h0002_0000, 0, 0, 0);
        push_request(OP_MATRIX, 0, 0, 32'hfffe_0000, 0, 0, 0);
        push_request(OP_READ, 0, 0, 0, 0, 0, 0);
        // negative product rounds toward minus infinity
        push_request(OP_MATRIX, 2, 2, 32'hffff_ffff, 0, 0, 0);
        push_request(OP_READ, 2, 0, 0, 0, 0, 0);
        // unused op code with every field at all ones
        push_request(OP_UNUSED, 63, 63, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff, 32'hffff_ffff);
        // saturation both ways
        push_request(OP_MATRIX, 63, 1, 32'h7fff_ffff, 0, 0, 0);
        push_request(OP_READ, 1, 0, 0, 0, 0, 0);
        push_request(OP_READ, 63, 0, 0, 0, 0, 0);
        push_request(OP_MATRIX, 3, 3, 32'h8000_0000, 0, 0, 0);
        push_request(OP_READ, 3, 0, 0, 0, 0, 0);
        push_random_requests(380);

        // smallest nonzero dimension: bad index on every op
        change_dimension(1, 30);
        push_request(OP_LOAD, 5, 0, 0, 32'h0001_0000, 0, 0);
        push_request(OP_MATRIX, 0, 5, 32'h0001_0000, 0, 0, 0);
        push_request(OP_MATRIX, 5, 0, 32'h0001_0000, 0, 0, 0);
        push_request(OP_READ, 40, 0, 0, 0, 0, 0);
        push_request(OP_READ, 0, 0, 0, 0, 0, 0);
        push_random_requests(150);

        // zero dimension: every index is bad
        change_dimension(0, 30);
        push_request(OP_READ, 0, 0, 0, 0, 0, 0);
        push_request(OP_LOAD, 0, 0, 0, 32'h0001_0000, 0, 0);
        push_request(OP_MATRIX, 0, 0, 32'h0001_0000, 0, 0, 0);
        push_random_requests(40);

        // dimension above the memory depth
        change_dimension(127, 60);
        push_request(OP_READ, 63, 0, 0, 0, 0, 0);
        push_request(OP_MATRIX, 63, 0, 32'h0000_8000, 0, 0, 0);
        push_request(OP_READ, 0, 0, 0, 0, 0, 0);
        push_random_requests(380);

        change_dimension(8, 60);
        push_random_requests(300);

        change_dimension(64, 0);
        push_random_requests(300);

        change_dimension(100, 0);
        push_random_requests(250);

        drain_requests();
        $display("covered %0d requests: %0d loads, %0d matrix elements, %0d reads, %0d unused",
            n_load + n_matrix + n_read + n_unused, n_load, n_matrix, n_read, n_unused);
        $display("%0d bad-index requests, %0d read results checked over %0d dimension settings",
            n_bad, results_checked, n_settings);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dmva_pkg.sv
hw/rtl/dmva_datapath.sv
hw/rtl/dmva_ctrl.sv
hw/rtl/dual_matrix_vector_accumulate.sv
tb/sv/tb.sv
